// File: hdl/hint_vector_decoder_checker_unit_defines.svh
// Assertion macros used by the hint decoder back end.
`ifndef HINT_VECTOR_DECODER_CHECKER_UNIT_DEFINES_SVH
`define HINT_VECTOR_DECODER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HVDC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hvdc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HVDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hvdc: next-cycle check failed");

`endif

// File: hdl/hvdc_pkg.sv
// Types and constants shared by the hint decoder modules.
package hvdc_pkg;

	localparam int WORD_BITS      = 64;
	localparam int WORDS_PER_POLY = 4;

	// One classified byte of the hint section on its way to the back end.
	typedef struct packed {
		logic       is_count;
		logic       is_last;
		logic [6:0] slot;
		logic [7:0] value;
	} hvdc_item_t;

endpackage

// File: hdl/hvdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hvdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/hvdc_front.sv
// Front end: takes hint bytes, tracks their place in the section and classifies them.
module hvdc_front #(
	parameter int POLYS     = 4,
	parameter int MAX_HINTS = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          hint_byte,
	input  logic                q_full,
	output logic                q_push,
	output hvdc_pkg::hvdc_item_t q_item
);
	import hvdc_pkg::*;

	localparam int SECTION = MAX_HINTS + POLYS;
	localparam int AW      = $clog2(SECTION);

	logic [AW-1:0] pos_q;
	logic          is_count;
	logic          is_last;
	logic [AW-1:0] slot;

	assign full     = q_full;
	assign q_push   = push && !q_full;
	assign is_count = pos_q >= AW'(MAX_HINTS);
	assign is_last  = pos_q == AW'(SECTION - 1);
	// Count bytes are numbered from zero by polynomial.
	assign slot     = is_count ? pos_q - AW'(MAX_HINTS) : pos_q;

	always_comb begin
		q_item          = '0;
		q_item.is_count = is_count;
		q_item.is_last  = is_last;
		q_item.slot     = 7'(slot);
		q_item.value    = hint_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= is_last ? '0 : pos_q + AW'(1);
		end
	end

endmodule

// File: hdl/hvdc_queue.sv
// Two-entry queue of classified items between front and back end.
module hvdc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  hvdc_pkg::hvdc_item_t wdata,
	output logic                 q_full,
	input  logic                 rd,
	output hvdc_pkg::hvdc_item_t rdata,
	output logic                 q_empty
);
	import hvdc_pkg::*;

	hvdc_item_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr && !q_full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !q_full) begin
				wr_q <= ~wr_q;
			end
			if (rd && !q_empty) begin
				rd_q <= ~rd_q;
			end
			case ({wr && !q_full, rd && !q_empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/hvdc_back.sv
// Back end: stores the section, walks the hint indices and emits the decoded words.
`include "hint_vector_decoder_checker_unit_defines.svh"

module hvdc_back #(
	parameter int POLYS     = 4,
	parameter int MAX_HINTS = 80
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hvdc_pkg::hvdc_item_t q_item,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           poly_index,
	output logic [1:0]           word_index,
	output logic [63:0]          hint_bits,
	output logic                 malformed,
	output logic                 last_word
);
	import hvdc_pkg::*;

	localparam int HW  = MAX_HINTS > 1 ? $clog2(MAX_HINTS) : 1;
	localparam int PIW = POLYS > 1 ? $clog2(POLYS) : 1;
	localparam int PW  = $clog2(POLYS + 1);
	localparam int JW  = $clog2(MAX_HINTS + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [7:0]             cnt_q [POLYS];
	logic [7:0]             prev_cnt_q;
	logic                   cnt_bad_q;
	logic                   bad_q;
	logic [PW-1:0]          p_q;
	logic [JW-1:0]          j_q;
	logic                   first_q;
	logic [7:0]             last_q;
	logic [PIW-1:0]         ep_q;
	logic [1:0]             ew_q;
	logic [WORD_BITS-1:0]   bits_q [POLYS][WORDS_PER_POLY];
	logic                   out_valid_q;
	logic [1:0]             out_poly_q;
	logic [1:0]             out_word_q;
	logic [WORD_BITS-1:0]   out_bits_q;
	logic                   out_mal_q;
	logic                   out_last_q;

	logic                   store_we;
	logic [7:0]             rdata;
	logic [PIW-1:0]         p_idx;
	logic                   p_live;
	logic                   count_bad;
	logic                   out_take;
	logic                   emit_load;
	logic                   emit_final;
	logic                   set_bit;
	logic                   clear_bits;
	logic [PIW+1:0]         ep_ext;

	assign q_pop      = (state_q == ST_LOAD) && !q_empty;
	assign store_we   = q_pop && !q_item.is_count;
	assign p_idx      = p_q[PIW-1:0];
	assign p_live     = p_q < PW'(POLYS);
	assign count_bad  = (q_item.value < prev_cnt_q) || (q_item.value > 8'(MAX_HINTS));
	assign out_take   = pop && out_valid_q;
	assign emit_load  = (state_q == ST_EMIT) && (!out_valid_q || pop);
	assign emit_final = (ep_q == PIW'(POLYS - 1)) && (ew_q == 2'd3);
	assign set_bit    = (state_q == ST_CHECK) && p_live;
	assign clear_bits = q_pop && q_item.is_count && q_item.is_last;
	assign ep_ext     = (PIW + 2)'(ep_q);

	assign empty      = !out_valid_q;
	assign poly_index = out_poly_q;
	assign word_index = out_word_q;
	assign hint_bits  = out_bits_q;
	assign malformed  = out_mal_q;
	assign last_word  = out_last_q;

	hvdc_ram #(
		.WIDTH(8),
		.DEPTH(MAX_HINTS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(q_item.slot[HW-1:0]),
		.wdata(q_item.value),
		.raddr(j_q[HW-1:0]),
		.rdata(rdata)
	);

	// Hint bitmap: wipe at the start of a decode, then set one bit per index.
	always_ff @(posedge clk) begin
		if (clear_bits) begin
			for (int p = 0; p < POLYS; p++) begin
				for (int w = 0; w < WORDS_PER_POLY; w++) begin
					bits_q[p][w] <= '0;
				end
			end
		end else if (set_bit) begin
			bits_q[p_idx][rdata[7:6]][rdata[5:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			prev_cnt_q  <= '0;
			cnt_bad_q   <= 1'b0;
			bad_q       <= 1'b0;
			p_q         <= '0;
			j_q         <= '0;
			first_q     <= 1'b0;
			last_q      <= '0;
			ep_q        <= '0;
			ew_q        <= '0;
			out_valid_q <= 1'b0;
			out_poly_q  <= '0;
			out_word_q  <= '0;
			out_bits_q  <= '0;
			out_mal_q   <= 1'b0;
			out_last_q  <= 1'b0;
			for (int p = 0; p < POLYS; p++) begin
				cnt_q[p] <= '0;
			end
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop && q_item.is_count) begin
						cnt_q[q_item.slot[PIW-1:0]] <= q_item.value;
						prev_cnt_q <= q_item.is_last ? 8'd0 : q_item.value;
						if (count_bad) begin
							cnt_bad_q <= 1'b1;
							bad_q     <= 1'b1;
						end
						if (q_item.is_last) begin
							p_q        <= '0;
							j_q        <= '0;
							first_q    <= 1'b1;
							ep_q       <= '0;
							ew_q       <= '0;
							// Skip the walk when the counts are already broken.
							state_q    <= (cnt_bad_q || count_bad) ? ST_EMIT : ST_READ;
						end
					end
				end
				ST_READ: begin
					// Advance past polynomials whose range ends here, else read index j.
					if (p_live && (8'(j_q) >= cnt_q[p_idx])) begin
						p_q     <= p_q + PW'(1);
						first_q <= 1'b1;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (p_live) begin
						if (!first_q && (rdata <= last_q)) begin
							bad_q <= 1'b1;
						end
						last_q  <= rdata;
						first_q <= 1'b0;
					end else if (rdata != 8'd0) begin
						bad_q <= 1'b1;
					end
					if (j_q == JW'(MAX_HINTS - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						j_q     <= j_q + JW'(1);
						state_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_poly_q  <= ep_ext[1:0];
						out_word_q  <= ew_q;
						out_bits_q  <= bad_q ? '0 : bits_q[ep_q][ew_q];
						out_mal_q   <= bad_q;
						out_last_q  <= emit_final;
						ew_q        <= ew_q + 2'd1;
						if (ew_q == 2'd3) begin
							ep_q <= ep_q + PIW'(1);
						end
						if (emit_final) begin
							bad_q     <= 1'b0;
							cnt_bad_q <= 1'b0;
							state_q   <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`HVDC_ASSERT_IMPLIES(a_mal_zero, out_valid_q && out_mal_q, out_bits_q == '0)
	`HVDC_ASSERT_IMPLIES(a_poly_bound, state_q != ST_LOAD, p_q <= PW'(POLYS))
	`HVDC_ASSERT_IMPLIES(a_read_bound, state_q == ST_CHECK, j_q < JW'(MAX_HINTS))
	`HVDC_ASSERT_NEXT(a_emit_done, emit_load && emit_final, (state_q == ST_LOAD) && out_last_q)

endmodule

// File: hdl/hint_vector_decoder_checker_unit.sv
// Flow: bytes are taken one per cycle while the back end loads and the queue is not full; after
// the last count byte the index walk does one store read and one check per index, with a step to
// each next polynomial in between, then POLYS*4 words leave one per cycle as pop allows.
// Bytes of the next section are held off by full, beyond the two queued items, until the emit ends.
// Reset: arst_n clears the byte position, queue, sequencer and output register; the section
// store is not cleared, as every entry is written before it is read.
module hint_vector_decoder_checker_unit #(
	parameter int POLYS     = 4,
	parameter int MAX_HINTS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  hint_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  poly_index,
	output logic [1:0]  word_index,
	output logic [63:0] hint_bits,
	output logic        malformed,
	output logic        last_word
);
	import hvdc_pkg::*;

	hvdc_item_t f_item;
	hvdc_item_t b_item;
	logic       f_push;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;

	hvdc_front #(
		.POLYS    (POLYS),
		.MAX_HINTS(MAX_HINTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.hint_byte(hint_byte),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_item   (f_item)
	);

	hvdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (f_item),
		.q_full (q_full),
		.rd     (q_pop),
		.rdata  (b_item),
		.q_empty(q_empty)
	);

	hvdc_back #(
		.POLYS    (POLYS),
		.MAX_HINTS(MAX_HINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (b_item),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.poly_index(poly_index),
		.word_index(word_index),
		.hint_bits (hint_bits),
		.malformed (malformed),
		.last_word (last_word)
	);

endmodule
